// File: rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers for the base64 decoder
// Command word passed from the front end to the back end, queue status,
// character constants, the alphabet lookup and the byte assembly functions.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Special characters of the standard alphabet.
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  // Number of result items carried by one command.
  localparam logic [1:0] NUM_ONE   = 2'd1;
  localparam logic [1:0] NUM_TWO   = 2'd2;
  localparam logic [1:0] NUM_THREE = 2'd3;

  // One queued command: up to three bytes, delivered lowest index first.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      num;
    logic            has_data;
    logic            last;
  } b64d_cmd_t;

  // Status of the command queue.
  typedef struct packed {
    logic empty;
    logic full;
  } b64d_fifo_stat_t;

  // Returns {valid, value}; valid is low for bytes outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41;
        sextet_of = {1'b1, d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        d = c - 8'h61 + 8'd26;
        sextet_of = {1'b1, d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30 + 8'd52;
        sextet_of = {1'b1, d[5:0]};
      end else if (c == CHAR_PLUS) begin
        sextet_of = {1'b1, 6'd62};
      end else if (c == CHAR_SLASH) begin
        sextet_of = {1'b1, 6'd63};
      end else begin
        sextet_of = {1'b0, d[5:0]};
      end
    end
  endfunction

  function automatic logic [7:0] first_byte(input logic [5:0] a, input logic [5:0] b);
    first_byte = {a, b[5:4]};
  endfunction

  function automatic logic [7:0] second_byte(input logic [5:0] b, input logic [5:0] c);
    second_byte = {b[3:0], c[5:2]};
  endfunction

  function automatic logic [7:0] third_byte(input logic [5:0] c, input logic [5:0] d);
    third_byte = {c[1:0], d};
  endfunction

endpackage

// File: rtl/base64_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder_top: streaming base64 decoder, standard alphabet
// Turns a character stream into decoded bytes, one character per transfer.
// ----------------------------------------------------------------------------
// The decoder takes one ASCII character per clock cycle on a queue-style
// input (push/full) and delivers decoded bytes on a queue-style output
// (empty/pop), one result per cycle. Every fourth valid character yields
// three bytes; the first '=' or any byte outside the alphabet stops decoding
// until the character marked last, which flushes a partial group (two
// pending values give one byte, three give two) and always ends with a
// result marked last_byte; if that end carries no byte, has_data is 0 and
// data_byte is 0. The front end classifies each character in the cycle of
// its transfer and writes a command into a queue of CMD_FIFO_DEPTH entries;
// the first result of a command shows on the output once it heads the
// queue. Input accepts a character every cycle while the queue has room,
// so a stalled output does not stop intake until the queue fills. The
// sustained rate is one character per cycle as long as the output keeps up.
// A string never yields more results than it has characters: four valid
// characters give three results and a flush or an empty end gives at most
// one result per character. The single output port, at one result per
// cycle, therefore keeps pace with a dense stream, and the queue absorbs
// the three results of a full group.
module base64_decoder_top
  import b64d_pkg::*;
#(
  parameter int CMD_FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char_byte,
  input  logic       in_last_char,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_data_byte,
  output logic       out_has_data,
  output logic       out_last_byte
);

  b64d_cmd_t       push_cmd;
  b64d_cmd_t       head_cmd;
  b64d_fifo_stat_t fifo_stat;
  logic            cmd_push;
  logic            cmd_pop;

  // Front end: alphabet lookup, pending group, halt flag.
  b64d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_char_byte (in_char_byte),
    .in_last_char (in_last_char),
    .fifo_stat    (fifo_stat),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd)
  );

  // Queue decouples character intake from result delivery.
  b64d_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  // Back end: one result per output transfer.
  b64d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_cmd      (head_cmd),
    .fifo_stat     (fifo_stat),
    .cmd_pop       (cmd_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data_byte (out_data_byte),
    .out_has_data  (out_has_data),
    .out_last_byte (out_last_byte)
  );

endmodule

// File: rtl/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front: character intake and classification
// Maps each character to its 6-bit value, keeps the pending group and the
// halt flag, and queues one command per completed group or end of string.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [7:0]      in_char_byte,
  input  logic            in_last_char,
  input  b64d_fifo_stat_t fifo_stat,
  output logic            cmd_push,
  output b64d_cmd_t       cmd
);

  logic [2:0][5:0] buf_r, buf_nxt, buf_a;
  logic [1:0]      cnt_r, cnt_nxt, cnt_a;
  logic            halted_r, halted_nxt, halt_a;
  logic [6:0]      sx;
  logic            sx_ok;
  logic            grp;
  logic            accept;

  assign in_full = fifo_stat.full;
  assign accept  = in_push && !fifo_stat.full;
  assign sx      = sextet_of(in_char_byte);
  assign sx_ok   = sx[6] && (in_char_byte != CHAR_PAD);

  // State update for one character.
  always_comb begin
    buf_a  = buf_r;
    cnt_a  = cnt_r;
    halt_a = halted_r;
    grp    = 1'b0;
    if (!halted_r) begin
      if (!sx_ok) begin
        halt_a = 1'b1;
      end else if (cnt_r == NUM_THREE) begin
        grp   = 1'b1;
        cnt_a = 2'd0;
      end else begin
        case (cnt_r)
          2'd0:    buf_a[0] = sx[5:0];
          2'd1:    buf_a[1] = sx[5:0];
          default: buf_a[2] = sx[5:0];
        endcase
        cnt_a = cnt_r + 2'd1;
      end
    end
  end

  // Command built from the updated state.
  always_comb begin
    cmd.bytes    = '0;
    cmd.num      = NUM_ONE;
    cmd.has_data = 1'b1;
    cmd.last     = in_last_char;
    if (grp) begin
      cmd.bytes[0] = first_byte(buf_r[0], buf_r[1]);
      cmd.bytes[1] = second_byte(buf_r[1], buf_r[2]);
      cmd.bytes[2] = third_byte(buf_r[2], sx[5:0]);
      cmd.num      = NUM_THREE;
    end else if (cnt_a == NUM_THREE) begin
      cmd.bytes[0] = first_byte(buf_a[0], buf_a[1]);
      cmd.bytes[1] = second_byte(buf_a[1], buf_a[2]);
      cmd.num      = NUM_TWO;
    end else if (cnt_a == NUM_TWO) begin
      cmd.bytes[0] = first_byte(buf_a[0], buf_a[1]);
    end else begin
      cmd.has_data = 1'b0;
    end
  end

  assign cmd_push = accept && (grp || in_last_char);

  always_comb begin
    buf_nxt    = buf_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    if (accept) begin
      buf_nxt = buf_a;
      if (in_last_char) begin
        cnt_nxt    = 2'd0;
        halted_nxt = 1'b0;
      end else begin
        cnt_nxt    = cnt_a;
        halted_nxt = halt_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      halted_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

// File: rtl/b64d_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_cmd_fifo: command queue between front and back end
// Small register queue; the head entry is presented without a pop.
// ----------------------------------------------------------------------------
module b64d_cmd_fifo
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64d_cmd_t       push_cmd,
  input  logic            pop,
  output b64d_cmd_t       head_cmd,
  output b64d_fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64d_cmd_t        mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back: result serializer
// Walks the bytes of the head command one result per transfer and retires
// the command after its final byte.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  b64d_cmd_t       head_cmd,
  input  b64d_fifo_stat_t fifo_stat,
  output logic            cmd_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_data_byte,
  output logic            out_has_data,
  output logic            out_last_byte
);

  logic [1:0] idx_r, idx_nxt;
  logic       xfer;
  logic       final_byte;

  assign out_empty  = fifo_stat.empty;
  assign xfer       = out_pop && !fifo_stat.empty;
  assign final_byte = (idx_r == head_cmd.num - 2'd1);
  assign cmd_pop    = xfer && final_byte;

  always_comb begin
    case (idx_r)
      2'd0:    out_data_byte = head_cmd.bytes[0];
      2'd1:    out_data_byte = head_cmd.bytes[1];
      default: out_data_byte = head_cmd.bytes[2];
    endcase
  end

  assign out_has_data  = head_cmd.has_data;
  assign out_last_byte = head_cmd.last && final_byte;

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = final_byte ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// File: rtl/b64d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker: port-level assertions for the base64 decoder
// Watches the top-level ports only and is bound to every decoder instance.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_data_byte,
  input logic       out_has_data,
  input logic       out_last_byte
);

  // A waiting result does not change until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_data_byte) && $stable(out_has_data)
       && $stable(out_last_byte)))
    else $error("waiting result changed before its transfer");

  // An empty end marker always closes the string.
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_has_data) |-> out_last_byte)
    else $error("result without data is not marked last");

  // An empty end marker carries a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_has_data) |-> (out_data_byte == 8'h00))
    else $error("empty end marker carries a nonzero byte");

  // Reset leaves no result waiting and room for input.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("decoder not clear after reset");

endmodule

bind base64_decoder_top b64d_checker u_b64d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_data_byte (out_data_byte),
  .out_has_data  (out_has_data),
  .out_last_byte (out_last_byte)
);
